// ===== hw/rtl/smva_pkg.sv =====
// Shared types and constants for the coordinate-format sparse matrix-vector block.
// Used by smva_ctrl, smva_dp and the top level sparse_matrix_vector_accumulate.
// Holds the action codes, field widths, stream packing and the controller/datapath structs.
package smva_pkg;

  localparam int DIM_DEF = 512;
  // Wide enough to compare any index against the largest supported DIM (4096).
  localparam int DIM_CMP_W = 13;

  localparam int ACT_W = 2;
  localparam int IDX_W = 9;
  localparam int VAL_W = 32;
  localparam int SUM_W = 48;
  localparam int FRAC_W = 16;

  localparam int IN_BITS = 2 * IDX_W + VAL_W;
  localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 2 * SUM_W + 1;
  localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD = 2'd0,
    ACT_ACC  = 2'd1,
    ACT_READ = 2'd2
  } action_t;

  typedef struct packed {
    logic latch;
    logic clr_we;
    logic vec_we;
    logic fetch;
    logic mul;
    logic sum_we;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_read;
    logic clear_done;
  } dp_stat_t;

endpackage

// ===== hw/rtl/smva_ctrl.sv =====
// Controller state machine for the sparse matrix-vector block.
// Depends on smva_pkg; sequences the clearing pass and each action through smva_dp.
module smva_ctrl
  import smva_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [ACT_W-1:0] in_action,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output dp_cmd_t          cmd,
  input  dp_stat_t         stat
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_FETCH = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_ADD   = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_ready && in_valid;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.latch = accept;
        if (accept) begin
          unique case (in_action)
            ACT_LOAD: state_next = S_LOAD;
            ACT_ACC:  state_next = S_FETCH;
            ACT_READ: state_next = S_FETCH;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd.vec_we = 1'b1;
        state_next = S_IDLE;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = stat.is_read ? S_RESP : S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.sum_we = 1'b1;
        state_next = S_IDLE;
      end
      S_RESP: begin
        // The result register frees up in the same cycle its transfer completes.
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register loaded while a result is still pending");

  a_sum_after_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.sum_we |-> $past(cmd.mul))
    else $error("sum write without a preceding multiply step");

  a_acc_path: assert property (@(posedge clk) disable iff (rst)
    (accept && in_action == ACT_ACC) |=> ##2 cmd.sum_we)
    else $error("accumulate did not reach the sum write step");

endmodule

// ===== hw/rtl/smva_dp.sv =====
// Datapath for the sparse matrix-vector block: vector and sum memories,
// the two product multipliers, the saturating adders and the result register.
// Depends on smva_pkg; driven by commands from smva_ctrl.
module smva_dp
  import smva_pkg::*;
#(
  parameter int DIM = DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [ACT_W-1:0]     in_action,
  input  logic [S_TDATA_W-1:0] in_data,
  output logic [M_TDATA_W-1:0] out_data,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat
);

  localparam int AW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam logic [DIM_CMP_W-1:0] DIM_C = DIM_CMP_W'(DIM);
  localparam logic [AW-1:0] LAST_A = AW'(DIM - 1);
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  logic signed [VAL_W-1:0] vec_mem [DIM];
  logic signed [SUM_W-1:0] fwd_mem [DIM];
  logic signed [SUM_W-1:0] trn_mem [DIM];

  logic                    is_read;
  logic                    row_ok;
  logic                    col_ok;
  logic [AW-1:0]           row_a;
  logic [AW-1:0]           col_a;
  logic signed [VAL_W-1:0] val_q;
  logic [AW-1:0]           clr_cnt;

  logic signed [VAL_W-1:0] xr;
  logic signed [VAL_W-1:0] xc;
  logic signed [SUM_W-1:0] fsum_rd;
  logic signed [SUM_W-1:0] tsum_rd;
  logic signed [SUM_W-1:0] prod_f;
  logic signed [SUM_W-1:0] prod_t;

  logic signed [2*VAL_W-1:0] mul_f;
  logic signed [2*VAL_W-1:0] mul_t;
  logic signed [SUM_W:0]     add_f;
  logic signed [SUM_W:0]     add_t;
  logic                      ovf_f;
  logic                      ovf_t;
  logic signed [SUM_W-1:0]   fwd_new;
  logic signed [SUM_W-1:0]   trn_new;
  logic                      acc_ok;

  logic                    sat_flag;
  logic signed [SUM_W-1:0] fwd_out;
  logic signed [SUM_W-1:0] trn_out;
  logic                    sat_out;

  logic [IDX_W-1:0] in_row;
  logic [IDX_W-1:0] in_col;
  logic [VAL_W-1:0] in_val;

  assign in_row = in_data[IDX_W-1:0];
  assign in_col = in_data[2*IDX_W-1:IDX_W];
  assign in_val = in_data[IN_BITS-1:2*IDX_W];

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      is_read <= (in_action == ACT_READ);
      row_ok  <= (DIM_CMP_W'(in_row) < DIM_C);
      col_ok  <= (DIM_CMP_W'(in_col) < DIM_C);
      row_a   <= AW'(in_row);
      col_a   <= AW'(in_col);
      val_q   <= $signed(in_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // Products are dropped to Q32.16 by an arithmetic shift, which rounds toward minus infinity.
  assign mul_f = val_q * xc;
  assign mul_t = val_q * xr;

  assign add_f = {fsum_rd[SUM_W-1], fsum_rd} + {prod_f[SUM_W-1], prod_f};
  assign add_t = {tsum_rd[SUM_W-1], tsum_rd} + {prod_t[SUM_W-1], prod_t};
  assign ovf_f = add_f[SUM_W] ^ add_f[SUM_W-1];
  assign ovf_t = add_t[SUM_W] ^ add_t[SUM_W-1];
  assign fwd_new = ovf_f ? (add_f[SUM_W] ? SUM_MIN : SUM_MAX) : add_f[SUM_W-1:0];
  assign trn_new = ovf_t ? (add_t[SUM_W] ? SUM_MIN : SUM_MAX) : add_t[SUM_W-1:0];
  assign acc_ok  = row_ok && col_ok;

  always_ff @(posedge clk) begin
    if (cmd.clr_we) begin
      vec_mem[clr_cnt] <= '0;
      fwd_mem[clr_cnt] <= '0;
      trn_mem[clr_cnt] <= '0;
    end else begin
      if (cmd.vec_we && row_ok) begin
        vec_mem[row_a] <= val_q;
      end
      if (cmd.sum_we && acc_ok) begin
        fwd_mem[row_a] <= fwd_new;
        trn_mem[col_a] <= trn_new;
      end
    end
    if (cmd.fetch) begin
      xr      <= vec_mem[row_a];
      xc      <= vec_mem[col_a];
      fsum_rd <= fwd_mem[row_a];
      tsum_rd <= trn_mem[is_read ? row_a : col_a];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_f <= mul_f[2*VAL_W-1:FRAC_W];
      prod_t <= mul_t[2*VAL_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_flag <= 1'b0;
    end else if (cmd.sum_we && acc_ok && (ovf_f || ovf_t)) begin
      sat_flag <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      fwd_out <= row_ok ? fsum_rd : '0;
      trn_out <= row_ok ? tsum_rd : '0;
      sat_out <= sat_flag;
    end
  end

  assign out_data = {{(M_TDATA_W-OUT_BITS){1'b0}}, sat_out, trn_out, fwd_out};

  assign stat.is_read    = is_read;
  assign stat.clear_done = (clr_cnt == LAST_A);

  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(sat_flag))
    else $error("saturation flag cleared outside reset");

  a_oob_read_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && !row_ok) |=> (fwd_out == '0 && trn_out == '0))
    else $error("read beyond the store did not return zero sums");

  a_clr_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.clr_we |=> $stable(clr_cnt))
    else $error("clear counter moved outside the clearing pass");

endmodule

// ===== hw/rtl/sparse_matrix_vector_accumulate.sv =====
// s_tready is high only in the idle state, so a new input is taken only after the
// current action ends: a load writes the vector store; an accumulate fetches,
// multiplies, then writes both sum stores; a read fetches, then loads the result
// register, which drives m_tvalid, once that register is free. Reset: rst (synchronous)
// starts a clearing pass that zeroes all three stores, one entry per cycle, with s_tready
// low; the saturation flag clears at once. Depends on smva_pkg, smva_ctrl and smva_dp.
module sparse_matrix_vector_accumulate
  import smva_pkg::*;
#(
  parameter int DIM = DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // s_tdata: row_index[8:0], col_index[17:9], value[49:18], zero fill above
  input  logic [S_TDATA_W-1:0] s_tdata,
  // s_tuser: action[1:0]
  input  logic [ACT_W-1:0]     s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata: forward_sum[47:0], transpose_sum[95:48], saturated[96], zero fill above
  output logic [M_TDATA_W-1:0] m_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  smva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_action (s_tuser),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  smva_dp #(
    .DIM (DIM)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_action (s_tuser),
    .in_data   (s_tdata),
    .out_data  (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
